@@ rtl/core/crrd_pkg.sv @@
// Package for the card reader reply deframer.
// Frame byte constants, result codes and the result record.
// No dependencies.
package crrd_pkg;

  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [7:0] CmdByteA  = 8'hA1;
  localparam logic [7:0] CmdByteB  = 8'h20;
  localparam logic [7:0] StatusOk  = 8'h00;
  localparam logic [3:0] LenShort  = 4'd8;
  localparam logic [3:0] LenLong   = 4'd12;

  // frame byte positions
  localparam logic [3:0] PosStart  = 4'd0;
  localparam logic [3:0] PosLength = 4'd1;
  localparam logic [3:0] PosCmdA   = 4'd2;
  localparam logic [3:0] PosCmdB   = 4'd3;
  localparam logic [3:0] PosStatus = 4'd4;
  localparam logic [3:0] PosType0  = 4'd5;
  localparam logic [3:0] PosType1  = 4'd6;
  localparam logic [3:0] PosNum0   = 4'd7;
  localparam logic [3:0] PosNum3   = 4'd10;

  typedef enum logic [1:0] {
    OUTCOME_READ       = 2'd0,
    OUTCOME_NO_CARD    = 2'd1,
    OUTCOME_BAD_CHECK  = 2'd2,
    OUTCOME_BAD_HEADER = 2'd3
  } outcome_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] card_type;
    logic [31:0] card_number;
  } result_t;

endpackage

@@ rtl/core/crrd_byte_if.sv @@
// Channel interfaces of the card reader reply deframer: received bytes in,
// parse results out. Depends on crrd_pkg.
interface crrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       clear;

  modport source (output valid, output rx_byte, output clear, input ready);
  modport sink   (input valid, input rx_byte, input clear, output ready);
endinterface

interface crrd_result_if;
  logic              valid;
  logic              ready;
  crrd_pkg::outcome_t outcome;
  logic [15:0]       card_type;
  logic [31:0]       card_number;

  modport source (output valid, output outcome, output card_type, output card_number,
                  input ready);
  modport sink   (input valid, input outcome, input card_type, input card_number,
                  output ready);
endinterface

@@ rtl/core/card_reader_reply_deframer.sv @@
// Card reader reply deframer: one byte per transfer in, at most one result out.
// A result is registered from the byte that ends or rejects the frame into the
//   output register, or the skid entry while it is held. One byte per cycle while the
//   skid is empty, set by the single parse step between state and output registers.
// Reset (rst, synchronous): parser waits for a start byte, all captures zero,
//   output and skid registers empty.
// Depends on crrd_pkg, crrd_byte_if, crrd_result_if.
module card_reader_reply_deframer (
  input  logic                 clk,
  input  logic                 rst,
  crrd_byte_if.sink            rx,
  crrd_result_if.source        res
);

  // Frame state
  logic [3:0]  pos, pos_next;
  logic [3:0]  frame_len, frame_len_next;
  logic [7:0]  xor_acc, xor_acc_next;
  logic [7:0]  status, status_next;
  logic [15:0] type_cap, type_cap_next;
  logic [31:0] num_cap, num_cap_next;

  // Output register plus one skid entry, so bytes keep flowing while a
  // result waits downstream.
  logic               out_valid;
  crrd_pkg::result_t  out_q;
  logic               skid_valid;
  crrd_pkg::result_t  skid_q;

  logic               accept;
  logic               out_take;
  logic               emit;
  crrd_pkg::result_t  new_res;

  assign rx.ready = !skid_valid;
  assign accept   = rx.valid && rx.ready;
  assign out_take = out_valid && res.ready;

  // Parse step: next frame state and the result, if this byte gives one.
  always_comb begin
    pos_next       = pos;
    frame_len_next = frame_len;
    xor_acc_next   = xor_acc;
    status_next    = status;
    type_cap_next  = type_cap;
    num_cap_next   = num_cap;
    emit           = 1'b0;
    new_res        = '{outcome: crrd_pkg::OUTCOME_READ, card_type: 16'd0,
                       card_number: 32'd0};

    if (accept) begin
      if (rx.clear) begin
        // timeout: drop any partial frame
        pos_next       = crrd_pkg::PosStart;
        frame_len_next = 4'd0;
        xor_acc_next   = 8'd0;
        status_next    = 8'd0;
        type_cap_next  = 16'd0;
        num_cap_next   = 32'd0;
      end else if (pos == crrd_pkg::PosStart) begin
        // hunt for a start byte; everything else is skipped
        if (rx.rx_byte == crrd_pkg::StartByte) begin
          pos_next       = crrd_pkg::PosLength;
          frame_len_next = 4'd0;
          xor_acc_next   = rx.rx_byte;
          status_next    = 8'd0;
          type_cap_next  = 16'd0;
          num_cap_next   = 32'd0;
        end
      end else begin
        // any other path ends in idle unless it advances below
        pos_next       = crrd_pkg::PosStart;
        frame_len_next = 4'd0;
        xor_acc_next   = 8'd0;
        status_next    = 8'd0;
        type_cap_next  = 16'd0;
        num_cap_next   = 32'd0;

        if (pos == crrd_pkg::PosLength) begin
          if (rx.rx_byte == {4'd0, crrd_pkg::LenShort} ||
              rx.rx_byte == {4'd0, crrd_pkg::LenLong}) begin
            pos_next       = crrd_pkg::PosCmdA;
            frame_len_next = rx.rx_byte[3:0];
            xor_acc_next   = xor_acc ^ rx.rx_byte;
          end else begin
            emit            = 1'b1;
            new_res.outcome = crrd_pkg::OUTCOME_BAD_HEADER;
          end
        end else if (pos >= frame_len || frame_len == 4'd0) begin
          // position outside the frame: silently resync
        end else if (pos == frame_len - 4'd1) begin
          // check byte
          emit = 1'b1;
          if (rx.rx_byte != ~xor_acc) begin
            new_res.outcome = crrd_pkg::OUTCOME_BAD_CHECK;
          end else if (status != crrd_pkg::StatusOk || frame_len != crrd_pkg::LenLong) begin
            new_res.outcome = crrd_pkg::OUTCOME_NO_CARD;
          end else begin
            new_res.outcome     = crrd_pkg::OUTCOME_READ;
            new_res.card_type   = type_cap;
            new_res.card_number = num_cap;
          end
        end else if ((pos == crrd_pkg::PosCmdA && rx.rx_byte != crrd_pkg::CmdByteA) ||
                     (pos == crrd_pkg::PosCmdB && rx.rx_byte != crrd_pkg::CmdByteB)) begin
          emit            = 1'b1;
          new_res.outcome = crrd_pkg::OUTCOME_BAD_HEADER;
        end else begin
          pos_next       = pos + 4'd1;
          frame_len_next = frame_len;
          xor_acc_next   = xor_acc ^ rx.rx_byte;
          status_next    = status;
          type_cap_next  = type_cap;
          num_cap_next   = num_cap;
          if (pos == crrd_pkg::PosStatus) begin
            status_next = rx.rx_byte;
          end else if (pos == crrd_pkg::PosType0 || pos == crrd_pkg::PosType1) begin
            type_cap_next = {type_cap[7:0], rx.rx_byte};
          end else if (pos >= crrd_pkg::PosNum0 && pos <= crrd_pkg::PosNum3) begin
            num_cap_next = {num_cap[23:0], rx.rx_byte};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= crrd_pkg::PosStart;
      frame_len <= 4'd0;
      xor_acc   <= 8'd0;
      status    <= 8'd0;
      type_cap  <= 16'd0;
      num_cap   <= 32'd0;
    end else begin
      pos       <= pos_next;
      frame_len <= frame_len_next;
      xor_acc   <= xor_acc_next;
      status    <= status_next;
      type_cap  <= type_cap_next;
      num_cap   <= num_cap_next;
    end
  end

  // Result valids. A new result only arrives while the skid is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (emit) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (!out_valid || out_take) begin
        out_q <= new_res;
      end else begin
        skid_q <= new_res;
      end
    end else if (out_take && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign res.valid       = out_valid;
  assign res.outcome     = out_q.outcome;
  assign res.card_type   = out_q.card_type;
  assign res.card_number = out_q.card_number;

  // Skid only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // Past the length byte, a legal frame length has been latched.
  a_len_latched: assert property (@(posedge clk) disable iff (rst)
    (pos != crrd_pkg::PosStart && pos != crrd_pkg::PosLength) |->
      (frame_len == crrd_pkg::LenShort || frame_len == crrd_pkg::LenLong))
    else $error("frame position advanced without a valid length");

  // Position never runs past the last byte of a long frame.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos < crrd_pkg::LenLong)
    else $error("frame position out of range");

  // Card data is zero unless the card was read.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.outcome != crrd_pkg::OUTCOME_READ) |->
      (out_q.card_type == 16'd0 && out_q.card_number == 32'd0))
    else $error("card data on a failed result");

  // A clear transfer always leaves the parser waiting for a start byte.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.clear) |=> (pos == crrd_pkg::PosStart && xor_acc == 8'd0))
    else $error("clear did not return parser to idle");

endmodule
